@@ sv/rwlt_pkg.sv @@
// Shared types and codes of the record reader/writer lock table.
// Operation and status codes, controller states and control structs.
// No dependencies.
package rwlt_pkg;

   localparam int RECORD_W = 16;
   localparam int CLIENT_W = 3;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_UNLOCK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_WRITER   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_READERS  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_HELD = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/rwlt_if.sv @@
// Handshake channels of the lock table: request words and response words.
// Uses rwlt_pkg for field widths.
interface rwlt_req_if
   import rwlt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [CLIENT_W-1:0] client;
   logic [RECORD_W-1:0] record_id;

   modport source (output valid, output kind, output client, output record_id, input ready);
   modport sink   (input valid, input kind, input client, input record_id, output ready);
endinterface

interface rwlt_rsp_if
   import rwlt_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                granted;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output granted, output status, input ready);
   modport sink   (input valid, input granted, input status, output ready);
endinterface

@@ sv/record_reader_writer_lock_table.sv @@
// Record reader/writer lock table: top level joining controller and datapath.
// Uses rwlt_pkg, rwlt_if, rwlt_ctrl, rwlt_datapath.
//
// Usage:
//   req channel: one word per request (kind, client, record_id); taken when
//   valid and ready are high at a rising clock edge. kind 0 read lock,
//   1 write lock, 2 unlock.
//   rsp channel: one word per request (granted, status), in request order.
//   Scan: the entry RAM is scanned one entry per cycle through its single
//   read port, then the response is decided and loaded. ready returns the
//   cycle after the response is loaded.
//   The next request may be taken while a response still waits; that
//   request completes its scan and then holds until the response register
//   is free, so a stalled receiver only delays, never drops, words.
//   Reset (synchronous, active high) marks every entry free and empties the
//   response register; no clearing pass is needed.
module record_reader_writer_lock_table
   import rwlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int NUM_CLIENTS   = 8
) (
   input  logic       clock,
   input  logic       reset,
   rwlt_req_if.sink   req,
   rwlt_rsp_if.source rsp
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   rwlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   rwlt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NUM_CLIENTS   (NUM_CLIENTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (dp_status),
      .req_kind      (req.kind),
      .req_client    (req.client),
      .req_record_id (req.record_id),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_granted   (rsp.granted),
      .rsp_status    (rsp.status)
   );

endmodule

@@ sv/rwlt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rwlt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/rwlt_ctrl.sv @@
// Controller of the lock table: accept, scan the entry RAM, decide and apply.
// Uses rwlt_pkg for states and the command/status structs.
module rwlt_ctrl
   import rwlt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
         end
         S_DRAIN: begin
         end
         S_DECIDE: begin
            cmd.apply = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ sv/rwlt_datapath.sv @@
// Datapath of the lock table: request registers, entry RAM scan, lock
// decision, valid bits and the response register. Uses rwlt_pkg, rwlt_ram.
module rwlt_datapath
   import rwlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16,
   parameter int NUM_CLIENTS   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [CLIENT_W-1:0] req_client,
   input  logic [RECORD_W-1:0] req_record_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_granted,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int MASK_W  = NUM_CLIENTS;
   localparam int ENTRY_W = RECORD_W + 1 + CLIENT_W + MASK_W;

   logic [KIND_W-1:0]   kind_ff;
   logic [CLIENT_W-1:0] client_ff;
   logic [RECORD_W-1:0] rec_ff;

   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_pend_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic              hit_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              hit_hw_ff;
   logic [CLIENT_W-1:0] hit_wc_ff;
   logic [MASK_W-1:0] hit_mask_ff;
   logic              free_ff;
   logic [IDX_W-1:0]  free_idx_ff;

   logic                rsp_valid_ff;
   logic                granted_ff;
   logic [STATUS_W-1:0] status_ff;

   logic [ENTRY_W-1:0]  rdata;
   logic [RECORD_W-1:0] rd_rec;
   logic                rd_hw;
   logic [CLIENT_W-1:0] rd_wc;
   logic [MASK_W-1:0]   rd_mask;

   logic                bad;
   logic [MASK_W-1:0]   bit_mask;
   logic                d_grant;
   logic [STATUS_W-1:0] d_status;
   logic                d_we;
   logic                d_set_valid;
   logic                d_clr_valid;
   logic [IDX_W-1:0]    d_target;
   logic                d_hw;
   logic [CLIENT_W-1:0] d_wc;
   logic [MASK_W-1:0]   d_mask;
   logic                ram_we;

   assign rd_rec  = rdata[ENTRY_W-1 -: RECORD_W];
   assign rd_hw   = rdata[MASK_W+CLIENT_W];
   assign rd_wc   = rdata[MASK_W+CLIENT_W-1 : MASK_W];
   assign rd_mask = rdata[MASK_W-1:0];

   assign ram_we = cmd.apply && d_we;

   rwlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (d_target),
      .wdata ({rec_ff, d_hw, d_wc, d_mask}),
      .re    (cmd.rd_en),
      .raddr (cnt_ff),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         client_ff <= req_client;
         rec_ff    <= req_record_id;
      end
   end

   // scan pointer; read data for rd_idx_ff arrives in the cycle after issue
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.rd_en;
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.rd_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_idx_ff <= cnt_ff;
      end
   end

   // first matching valid entry and lowest free entry
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_pend_ff) begin
         if (valid_ff[rd_idx_ff] && rd_rec == rec_ff && !hit_ff) begin
            hit_ff <= 1'b1;
         end
         if (!valid_ff[rd_idx_ff] && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         if (valid_ff[rd_idx_ff] && rd_rec == rec_ff && !hit_ff) begin
            hit_idx_ff  <= rd_idx_ff;
            hit_hw_ff   <= rd_hw;
            hit_wc_ff   <= rd_wc;
            hit_mask_ff <= rd_mask;
         end
         if (!valid_ff[rd_idx_ff] && !free_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   assign bad      = (32'(client_ff) >= NUM_CLIENTS);
   assign bit_mask = (MASK_W)'(1) << client_ff;

   always_comb begin
      d_grant     = 1'b0;
      d_status    = ST_NOT_HELD;
      d_we        = 1'b0;
      d_set_valid = 1'b0;
      d_clr_valid = 1'b0;
      d_target    = hit_ff ? hit_idx_ff : free_idx_ff;
      d_hw        = hit_hw_ff;
      d_wc        = hit_wc_ff;
      d_mask      = hit_mask_ff;
      if (!bad) begin
         case (kind_ff)
            KIND_READ: begin
               if (hit_ff && hit_hw_ff) begin
                  d_status = ST_WRITER;
               end else if (!hit_ff && !free_ff) begin
                  d_status = ST_FULL;
               end else begin
                  d_grant     = 1'b1;
                  d_status    = ST_OK;
                  d_we        = 1'b1;
                  d_set_valid = 1'b1;
                  if (hit_ff) begin
                     d_mask = hit_mask_ff | bit_mask;
                  end else begin
                     d_hw   = 1'b0;
                     d_wc   = '0;
                     d_mask = bit_mask;
                  end
               end
            end
            KIND_WRITE: begin
               if (hit_ff && hit_hw_ff) begin
                  d_status = ST_WRITER;
               end else if (hit_ff && hit_mask_ff != '0) begin
                  d_status = ST_READERS;
               end else if (!hit_ff && !free_ff) begin
                  d_status = ST_FULL;
               end else begin
                  d_grant     = 1'b1;
                  d_status    = ST_OK;
                  d_we        = 1'b1;
                  d_set_valid = 1'b1;
                  d_hw        = 1'b1;
                  d_wc        = client_ff;
                  d_mask      = hit_ff ? hit_mask_ff : '0;
               end
            end
            KIND_UNLOCK: begin
               if (hit_ff && hit_hw_ff && hit_wc_ff == client_ff) begin
                  d_grant = 1'b1;
                  d_hw    = 1'b0;
               end else if (hit_ff && (hit_mask_ff & bit_mask) != '0) begin
                  d_grant = 1'b1;
                  d_mask  = hit_mask_ff & ~bit_mask;
               end
               if (d_grant) begin
                  d_status = ST_OK;
                  d_we     = 1'b1;
                  if (!d_hw && d_mask == '0) d_clr_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.apply) begin
         if (d_clr_valid) begin
            valid_ff[d_target] <= 1'b0;
         end else if (d_set_valid) begin
            valid_ff[d_target] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         granted_ff <= d_grant;
         status_ff  <= d_status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = granted_ff;
   assign rsp_status  = status_ff;

   assign status.scan_last = (cnt_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

`ifndef NO_ASSERTIONS
   a_apply_free: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (granted_ff == (status_ff == ST_OK)))
      else $error("granted and status disagree");

   a_set_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.apply && d_set_valid) |=> valid_ff[$past(d_target)])
      else $error("claimed entry not marked valid");

   a_no_scan_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !cmd.rd_en && !rd_pend_ff)
      else $error("entry write during scan");
`endif

endmodule
